FILE: hdl/tcpu_pkg.sv
`default_nettype none

package tcpu_pkg;

    // word memory address width, 8 to 16
    localparam int unsigned ADDR_BITS = 16;

    localparam logic [15:0] VIDEO_BASE_RST = 16'h8000;

    // input item kinds
    localparam logic IN_LOAD = 1'b0;
    localparam logic IN_EXEC = 1'b1;

    // instruction opcodes, bits 15..12
    localparam logic [3:0] OP_WMEM = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_SKIP = 4'd3;
    localparam logic [3:0] OP_AND  = 4'd4;
    localparam logic [3:0] OP_OR   = 4'd5;
    localparam logic [3:0] OP_XOR  = 4'd6;
    localparam logic [3:0] OP_LSL  = 4'd7;
    localparam logic [3:0] OP_LSR  = 4'd8;
    localparam logic [3:0] OP_ASR  = 4'd9;
    localparam logic [3:0] OP_CALL = 4'd10;
    localparam logic [3:0] OP_JUMP = 4'd11;
    localparam logic [3:0] OP_LETL = 4'd12;
    localparam logic [3:0] OP_LETH = 4'd13;
    localparam logic [3:0] OP_MISC = 4'd15;

    // sub-codes of the misc opcode, bits 7..4
    localparam logic [3:0] SUB_RMEM = 4'd0;
    localparam logic [3:0] SUB_COPY = 4'd1;

    // skip tests, bits 10..8
    localparam logic [2:0] CMP_EQ  = 3'd0;
    localparam logic [2:0] CMP_NE  = 3'd1;
    localparam logic [2:0] CMP_SGT = 3'd2;
    localparam logic [2:0] CMP_SLT = 3'd3;
    localparam logic [2:0] CMP_GT  = 3'd4;
    localparam logic [2:0] CMP_GE  = 3'd5;
    localparam logic [2:0] CMP_LT  = 3'd6;
    localparam logic [2:0] CMP_LE  = 3'd7;

    // result status
    localparam logic [1:0] STAT_EXECUTED = 2'd0;
    localparam logic [1:0] STAT_ILLEGAL  = 2'd1;
    localparam logic [1:0] STAT_LOADED   = 2'd2;

    localparam logic [3:0]  REG_LINK   = 4'd15;
    localparam logic [11:0] JUMP_RET   = 12'h001;
    localparam logic [15:0] LOW_BYTE   = 16'h00ff;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_MEMRD
    } t_state;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [1:0]  status;
        logic        wr;
        logic [3:0]  widx;
        logic [15:0] wval;
        logic        video;
        logic        mem_wr;
        logic        mem_rd;
        logic [15:0] mem_addr;
        logic [15:0] mem_wdata;
    } t_exec;

    // register read on port a: r[d4] for leth, r15 for return, else r[i]
    function automatic logic [3:0] rf_port_a(input logic [15:0] word);
        logic [3:0] addr;
        if (word[15:12] == OP_LETH) begin
            addr = word[11:8];
        end else if (word[15:12] == OP_JUMP) begin
            addr = REG_LINK;
        end else begin
            addr = word[7:4];
        end
        return addr;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tcpu_in_if.sv
`default_nettype none

interface tcpu_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] load_address;
    logic [15:0] load_data;

    modport source (output valid, output opcode, output load_address, output load_data,
                    input ready);
    modport sink   (input valid, input opcode, input load_address, input load_data,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/tcpu_out_if.sv
`default_nettype none

interface tcpu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] executed_word;
    logic [15:0] next_pc;
    logic [1:0]  status;
    logic        reg_write_valid;
    logic [3:0]  reg_write_index;
    logic [15:0] reg_write_value;
    logic        video_touched;

    modport source (output valid, output executed_word, output next_pc, output status,
                    output reg_write_valid, output reg_write_index, output reg_write_value,
                    output video_touched, input ready);
    modport sink   (input valid, input executed_word, input next_pc, input status,
                    input reg_write_valid, input reg_write_index, input reg_write_value,
                    input video_touched, output ready);
endinterface

`default_nettype wire

FILE: hdl/tcpu_cfg_if.sv
`default_nettype none

interface tcpu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tcpu_ram.sv
`default_nettype none

module tcpu_ram #(
    parameter int unsigned ADDR_W = 16,
    parameter int unsigned DATA_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tcpu_regfile.sv
`default_nettype none

module tcpu_regfile import tcpu_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rd_en,
    input  wire logic [3:0]  i_rd_a_addr,
    input  wire logic [3:0]  i_rd_b_addr,
    output logic      [15:0] o_rd_a,
    output logic      [15:0] o_rd_b,
    input  wire logic        i_we,
    input  wire logic [3:0]  i_waddr,
    input  wire logic [15:0] i_wdata
);

    logic [15:0] r_mem [16];
    logic [15:0] r_vld;

    // an entry never written since reset reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_a <= r_vld[i_rd_a_addr] ? r_mem[i_rd_a_addr] : 16'h0000;
            o_rd_b <= r_vld[i_rd_b_addr] ? r_mem[i_rd_b_addr] : 16'h0000;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tcpu_alu.sv
`default_nettype none

module tcpu_alu import tcpu_pkg::*; (
    input  wire logic [15:0] i_word,
    input  wire logic [15:0] i_pc,
    input  wire logic [15:0] i_ra,
    input  wire logic [15:0] i_rb,
    input  wire logic [15:0] i_video_base,
    output t_exec            o_res
);

    logic [3:0]  op;
    logic [2:0]  d3;
    logic [3:0]  d4;
    logic        k;
    logic [3:0]  fi;
    logic [3:0]  fj;
    logic [7:0]  fb;
    logic [11:0] fc;
    logic [15:0] js;
    logic [15:0] v;
    logic [15:0] lg;
    logic [15:0] sb;
    logic [15:0] pc1;
    logic [3:0]  sh;
    logic        big;
    logic        hit;
    logic        vid;

    always_comb begin
        op  = i_word[15:12];
        d3  = i_word[10:8];
        d4  = i_word[11:8];
        k   = i_word[11];
        fi  = i_word[7:4];
        fj  = i_word[3:0];
        fb  = i_word[7:0];
        fc  = i_word[11:0];
        js  = {{12{fj[3]}}, fj};
        v   = k ? {12'h000, fj} : i_rb;
        lg  = k ? js : i_rb;
        sb  = k ? js : i_rb;
        pc1 = i_pc + 16'd1;
        sh  = v[3:0];
        big = |v[15:4];
        vid = i_rb >= i_video_base;

        hit = 1'b0;
        case (d3)
            CMP_EQ:  hit = i_ra == v;
            CMP_NE:  hit = i_ra != v;
            CMP_SGT: hit = $signed(i_ra) > $signed(sb);
            CMP_SLT: hit = $signed(i_ra) < $signed(sb);
            CMP_GT:  hit = i_ra > v;
            CMP_GE:  hit = i_ra >= v;
            CMP_LT:  hit = i_ra < v;
            default: hit = i_ra <= v;
        endcase

        o_res           = '0;
        o_res.next_pc   = pc1;
        o_res.status    = STAT_EXECUTED;
        o_res.mem_addr  = i_rb;
        o_res.mem_wdata = i_ra;

        unique case (op)
            OP_WMEM: begin
                if (d4 != 4'd0) begin
                    o_res.status = STAT_ILLEGAL;
                end else begin
                    o_res.mem_wr = 1'b1;
                    o_res.video  = vid;
                end
            end
            OP_ADD: begin
                o_res.wr = 1'b1; o_res.widx = {1'b0, d3}; o_res.wval = i_ra + v;
            end
            OP_SUB: begin
                o_res.wr = 1'b1; o_res.widx = {1'b0, d3}; o_res.wval = i_ra - v;
            end
            OP_SKIP: begin
                if (hit) begin
                    o_res.next_pc = i_pc + 16'd2;
                end
            end
            OP_AND: begin
                o_res.wr = 1'b1; o_res.widx = {1'b0, d3}; o_res.wval = i_ra & lg;
            end
            OP_OR: begin
                o_res.wr = 1'b1; o_res.widx = {1'b0, d3}; o_res.wval = i_ra | lg;
            end
            OP_XOR: begin
                o_res.wr = 1'b1; o_res.widx = {1'b0, d3}; o_res.wval = i_ra ^ lg;
            end
            OP_LSL: begin
                o_res.wr = 1'b1; o_res.widx = {1'b0, d3};
                o_res.wval = big ? 16'h0000 : (i_ra << sh);
            end
            OP_LSR: begin
                o_res.wr = 1'b1; o_res.widx = {1'b0, d3};
                o_res.wval = big ? 16'h0000 : (i_ra >> sh);
            end
            OP_ASR: begin
                o_res.wr = 1'b1; o_res.widx = {1'b0, d3};
                o_res.wval = big ? {16{i_ra[15]}} : 16'($signed(i_ra) >>> sh);
            end
            OP_CALL: begin
                o_res.wr      = 1'b1;
                o_res.widx    = REG_LINK;
                o_res.wval    = pc1;
                o_res.next_pc = {fc, 4'h0};
            end
            OP_JUMP: begin
                // port a carries r15 here
                if (fc == JUMP_RET) begin
                    o_res.next_pc = i_ra;
                end else begin
                    o_res.next_pc = i_pc + {{4{fc[11]}}, fc};
                end
            end
            OP_LETL: begin
                o_res.wr = 1'b1; o_res.widx = d4; o_res.wval = {{8{fb[7]}}, fb};
            end
            OP_LETH: begin
                // port a carries r[d4] here
                o_res.wr = 1'b1; o_res.widx = d4;
                o_res.wval = {fb, 8'h00} | (i_ra & LOW_BYTE);
            end
            OP_MISC: begin
                if (fi == SUB_RMEM) begin
                    o_res.wr = 1'b1; o_res.widx = d4;
                    o_res.mem_rd = 1'b1;
                    o_res.video  = vid;
                end else if (fi == SUB_COPY) begin
                    o_res.wr = 1'b1; o_res.widx = d4; o_res.wval = i_rb;
                end else begin
                    o_res.status = STAT_ILLEGAL;
                end
            end
            default: begin
                o_res.status = STAT_ILLEGAL;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/teaching_cpu_execute_step_top.sv
`default_nettype none

// 16-bit teaching processor, one input word per step. A load word writes one word
// into the internal word memory. An execute word fetches the instruction at pc,
// reads two registers and executes it in the steps fetch read, register read, and
// execute and write back; rmem adds a second read of the word memory. The word
// memory is one synchronous RAM with a write and a read port; its content is
// undefined until loaded. An input buffer takes the next word while the current
// one is at work, and an output register holds a finished result until it is
// taken. video_base may be written only while no word is in flight.
module teaching_cpu_execute_step_top import tcpu_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tcpu_in_if.sink    i_in,
    tcpu_out_if.source o_out,
    tcpu_cfg_if.sink   i_cfg
);

    t_state r_state, n_state;

    logic [15:0] r_pc;
    logic [15:0] r_video_base;
    logic [15:0] r_word;

    logic        r_ib_valid;
    logic        r_ib_op;
    logic [15:0] r_ib_addr;
    logic [15:0] r_ib_data;

    logic        r_ob_valid;
    logic [15:0] r_ob_word;
    logic [15:0] r_ob_npc;
    logic [1:0]  r_ob_status;
    logic        r_ob_wr;
    logic [3:0]  r_ob_widx;
    logic [15:0] r_ob_wval;
    logic        r_ob_video;

    logic                 out_free;
    logic                 ib_pop;
    logic                 emit;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [15:0]          ram_wdata;
    logic                 ram_re;
    logic [ADDR_BITS-1:0] ram_raddr;
    logic [15:0]          ram_rdata;
    logic                 rf_rd_en;
    logic [15:0]          rf_a;
    logic [15:0]          rf_b;
    logic                 rf_we;
    t_exec                ex;

    logic [15:0] e_word;
    logic [15:0] e_npc;
    logic [1:0]  e_status;
    logic        e_wr;
    logic [3:0]  e_widx;
    logic [15:0] e_wval;
    logic        e_video;

    tcpu_ram #(
        .ADDR_W (ADDR_BITS),
        .DATA_W (16)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tcpu_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (rf_rd_en),
        .i_rd_a_addr (rf_port_a(ram_rdata)),
        .i_rd_b_addr (ram_rdata[3:0]),
        .o_rd_a      (rf_a),
        .o_rd_b      (rf_b),
        .i_we        (rf_we),
        .i_waddr     (e_widx),
        .i_wdata     (e_wval)
    );

    tcpu_alu u_alu (
        .i_word       (r_word),
        .i_pc         (r_pc),
        .i_ra         (rf_a),
        .i_rb         (rf_b),
        .i_video_base (r_video_base),
        .o_res        (ex)
    );

    assign out_free    = !r_ob_valid || o_out.ready;
    assign i_in.ready  = !r_ib_valid || ib_pop;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state   = r_state;
        ib_pop    = 1'b0;
        emit      = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_ib_addr[ADDR_BITS-1:0];
        ram_wdata = r_ib_data;
        ram_re    = 1'b0;
        ram_raddr = r_pc[ADDR_BITS-1:0];
        rf_rd_en  = 1'b0;
        rf_we     = 1'b0;
        e_word    = r_word;
        e_npc     = ex.next_pc;
        e_status  = ex.status;
        e_wr      = ex.wr;
        e_widx    = ex.widx;
        e_wval    = ex.wval;
        e_video   = ex.video;

        unique case (r_state)
            ST_IDLE: begin
                if (r_ib_valid) begin
                    if (r_ib_op == IN_LOAD) begin
                        if (out_free) begin
                            ram_we   = 1'b1;
                            ib_pop   = 1'b1;
                            emit     = 1'b1;
                            e_word   = 16'h0000;
                            e_npc    = r_pc;
                            e_status = STAT_LOADED;
                            e_wr     = 1'b0;
                            e_widx   = 4'd0;
                            e_wval   = 16'h0000;
                            e_video  = 1'b0;
                        end
                    end else begin
                        ib_pop  = 1'b1;
                        ram_re  = 1'b1;
                        n_state = ST_DECODE;
                    end
                end
            end
            ST_DECODE: begin
                rf_rd_en = 1'b1;
                n_state  = ST_EXEC;
            end
            ST_EXEC: begin
                if (ex.mem_rd) begin
                    ram_re    = 1'b1;
                    ram_raddr = ex.mem_addr[ADDR_BITS-1:0];
                    n_state   = ST_MEMRD;
                end else if (out_free) begin
                    emit      = 1'b1;
                    rf_we     = ex.wr;
                    ram_we    = ex.mem_wr;
                    ram_waddr = ex.mem_addr[ADDR_BITS-1:0];
                    ram_wdata = ex.mem_wdata;
                    n_state   = ST_IDLE;
                end
            end
            ST_MEMRD: begin
                e_wval = ram_rdata;
                if (out_free) begin
                    emit    = 1'b1;
                    rf_we   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pc         <= 16'h0000;
            r_video_base <= VIDEO_BASE_RST;
            r_ib_valid   <= 1'b0;
            r_ob_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_pc <= e_npc;
            end
            if (i_cfg.valid) begin
                r_video_base <= i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                r_ib_valid <= 1'b1;
            end else if (ib_pop) begin
                r_ib_valid <= 1'b0;
            end
            r_ob_valid <= emit || (r_ob_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ib_op   <= i_in.opcode;
            r_ib_addr <= i_in.load_address;
            r_ib_data <= i_in.load_data;
        end
        if (r_state == ST_DECODE) begin
            r_word <= ram_rdata;
        end
        if (emit) begin
            r_ob_word   <= e_word;
            r_ob_npc    <= e_npc;
            r_ob_status <= e_status;
            r_ob_wr     <= e_wr;
            r_ob_widx   <= e_widx;
            r_ob_wval   <= e_wval;
            r_ob_video  <= e_video;
        end
    end

    assign o_out.valid           = r_ob_valid;
    assign o_out.executed_word   = r_ob_word;
    assign o_out.next_pc         = r_ob_npc;
    assign o_out.status          = r_ob_status;
    assign o_out.reg_write_valid = r_ob_wr;
    assign o_out.reg_write_index = r_ob_widx;
    assign o_out.reg_write_value = r_ob_wval;
    assign o_out.video_touched   = r_ob_video;

    // an execute word goes to register read right after its fetch
    a_fetch_then_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && ib_pop && r_ib_op == IN_EXEC) |=> r_state == ST_DECODE)
        else $error("fetch not followed by decode");

    // register file is never read and written in the same cycle
    a_rf_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rf_rd_en && rf_we))
        else $error("register read and write overlap");

    // pc moves only when a result is produced
    a_pc_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !emit |=> r_pc == $past(r_pc))
        else $error("pc changed without a result");

    // a load result never reports a register write or a video access
    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ob_valid && r_ob_status == STAT_LOADED) |-> (!r_ob_wr && !r_ob_video))
        else $error("load result carries a write");

endmodule

`default_nettype wire

FILE: tb/sv/tb_tcpu_checker.sv
`default_nettype none

module tb_tcpu_checker import tcpu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcpu_in_if        i_in,
    tcpu_out_if       i_out,
    tcpu_cfg_if       i_cfg,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MEM_WORDS = 2 ** ADDR_BITS;
    localparam logic [15:0] ADDR_MASK = 16'(MEM_WORDS - 1);

    typedef struct packed {
        logic [15:0] word;
        logic [15:0] next_pc;
        logic [1:0]  status;
        logic        wr;
        logic [3:0]  widx;
        logic [15:0] wval;
        logic        video;
    } t_step_result;

    // shadow machine state, also read by the stimulus to keep programs legal
    logic [15:0] pc_q;
    logic [15:0] regs_q [16];
    bit   [15:0] mem_q [MEM_WORDS];
    bit          loaded_q [MEM_WORDS];
    logic [15:0] video_base_q;

    t_step_result expected_q [$];

    task automatic report_error(input string what, input t_step_result want,
                                input t_step_result got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("[%0t] %s: expected word=%h pc=%h status=%0d wr=%b idx=%0d val=%h video=%b",
                     $time, what, want.word, want.next_pc, want.status, want.wr, want.widx,
                     want.wval, want.video);
            $display("[%0t] %s:   actual word=%h pc=%h status=%0d wr=%b idx=%0d val=%h video=%b",
                     $time, what, got.word, got.next_pc, got.status, got.wr, got.widx,
                     got.wval, got.video);
        end
    endtask

    task automatic predict_step(input logic kind, input logic [15:0] load_addr,
                                input logic [15:0] load_val);
        t_step_result r;
        logic [15:0] w, npc, ri, v, js, sb, res, dptr, opnd;
        logic [3:0]  op, d4, fi, fj, widx;
        logic [2:0]  d3;
        logic [7:0]  b;
        logic [11:0] c;
        logic [1:0]  status;
        logic        kf, wr, video, taken;
        r = '0;
        if (kind == IN_LOAD) begin
            mem_q[load_addr & ADDR_MASK] = load_val;
            loaded_q[load_addr & ADDR_MASK] = 1'b1;
            r.next_pc = pc_q;
            r.status = STAT_LOADED;
        end else begin
            w = mem_q[pc_q & ADDR_MASK];
            npc = pc_q + 16'd1;
            op = w[15:12];
            d3 = w[10:8];
            d4 = w[11:8];
            kf = w[11];
            fi = w[7:4];
            fj = w[3:0];
            b = w[7:0];
            c = w[11:0];
            js = {{12{fj[3]}}, fj};
            ri = regs_q[fi];
            dptr = regs_q[fj];
            v = kf ? {12'd0, fj} : dptr;
            opnd = kf ? js : dptr;
            wr = 1'b0;
            widx = {1'b0, d3};
            res = '0;
            status = STAT_EXECUTED;
            video = 1'b0;
            taken = 1'b0;
            case (op)
                OP_WMEM: begin
                    if (d4 != 4'd0) begin
                        status = STAT_ILLEGAL;
                    end else begin
                        mem_q[dptr & ADDR_MASK] = ri;
                        loaded_q[dptr & ADDR_MASK] = 1'b1;
                        video = dptr >= video_base_q;
                    end
                end
                OP_ADD: begin
                    wr = 1'b1;
                    res = ri + v;
                end
                OP_SUB: begin
                    wr = 1'b1;
                    res = ri - v;
                end
                OP_SKIP: begin
                    // signed tests see the immediate sign-extended
                    sb = kf ? js : v;
                    case (d3)
                        CMP_EQ:  taken = ri == v;
                        CMP_NE:  taken = ri != v;
                        CMP_SGT: taken = $signed(ri) > $signed(sb);
                        CMP_SLT: taken = $signed(ri) < $signed(sb);
                        CMP_GT:  taken = ri > v;
                        CMP_GE:  taken = ri >= v;
                        CMP_LT:  taken = ri < v;
                        default: taken = ri <= v;
                    endcase
                    if (taken) begin
                        npc = npc + 16'd1;
                    end
                end
                OP_AND: begin
                    wr = 1'b1;
                    res = ri & opnd;
                end
                OP_OR: begin
                    wr = 1'b1;
                    res = ri | opnd;
                end
                OP_XOR: begin
                    wr = 1'b1;
                    res = ri ^ opnd;
                end
                OP_LSL: begin
                    wr = 1'b1;
                    res = (v > 16'd15) ? 16'd0 : ri << v[3:0];
                end
                OP_LSR: begin
                    wr = 1'b1;
                    res = (v > 16'd15) ? 16'd0 : ri >> v[3:0];
                end
                OP_ASR: begin
                    wr = 1'b1;
                    if (v > 16'd15) begin
                        res = {16{ri[15]}};
                    end else begin
                        res = $signed(ri) >>> v[3:0];
                    end
                end
                OP_CALL: begin
                    wr = 1'b1;
                    widx = REG_LINK;
                    res = npc;
                    npc = {c, 4'd0};
                end
                OP_JUMP: begin
                    if (c == JUMP_RET) begin
                        npc = regs_q[REG_LINK];
                    end else begin
                        npc = pc_q + {{4{c[11]}}, c};
                    end
                end
                OP_LETL: begin
                    wr = 1'b1;
                    widx = d4;
                    res = {{8{b[7]}}, b};
                end
                OP_LETH: begin
                    wr = 1'b1;
                    widx = d4;
                    res = (regs_q[d4] & LOW_BYTE) | {b, 8'd0};
                end
                OP_MISC: begin
                    if (fi == SUB_RMEM) begin
                        wr = 1'b1;
                        widx = d4;
                        res = mem_q[dptr & ADDR_MASK];
                        video = dptr >= video_base_q;
                    end else if (fi == SUB_COPY) begin
                        wr = 1'b1;
                        widx = d4;
                        res = dptr;
                    end else begin
                        status = STAT_ILLEGAL;
                    end
                end
                default: begin
                    status = STAT_ILLEGAL;
                end
            endcase
            if (wr) begin
                regs_q[widx] = res;
            end
            pc_q = npc;
            r.word = w;
            r.next_pc = npc;
            r.status = status;
            r.wr = wr;
            r.widx = wr ? widx : 4'd0;
            r.wval = wr ? res : 16'd0;
            r.video = video;
        end
        expected_q.push_back(r);
    endtask

    always @(posedge i_clk) begin : monitor
        t_step_result got;
        t_step_result want;
        if (!i_rst_n) begin
            pc_q = '0;
            for (int n = 0; n < 16; n++) regs_q[n] = '0;
            video_base_q = VIDEO_BASE_RST;
            expected_q.delete();
            o_pending = 0;
            o_fail_count = 0;
            o_checked = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                video_base_q = i_cfg.data;
            end
            // a result is matched before the word taken on the same edge is predicted
            if (i_out.valid && i_out.ready) begin
                got = {i_out.executed_word, i_out.next_pc, i_out.status, i_out.reg_write_valid,
                       i_out.reg_write_index, i_out.reg_write_value, i_out.video_touched};
                if (expected_q.size() == 0) begin
                    report_error("result with no word pending", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        report_error("result mismatch", want, got);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_step(i_in.opcode, i_in.load_address, i_in.load_data);
            end
            o_pending = expected_q.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_teaching_cpu_execute_step_top.sv
`default_nettype none

module tb_teaching_cpu_execute_step_top import tcpu_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    localparam int ITEM_TARGET  = 1850;
    localparam int RAND_PHASES  = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [15:0] ADDR_MASK = 16'((2 ** ADDR_BITS) - 1);

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending_count;
    int checked_count;
    int n_loads;
    int n_execs;
    int n_cfg_writes;
    int cycle_count;

    tcpu_in_if  in_ch ();
    tcpu_out_if out_ch ();
    tcpu_cfg_if cfg_ch ();

    teaching_cpu_execute_step_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tb_tcpu_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // every task below starts and ends at a falling edge

    task automatic send_word(input logic kind, input logic [15:0] addr, input logic [15:0] data);
        in_ch.valid <= 1'b1;
        in_ch.opcode <= kind;
        in_ch.load_address <= addr;
        in_ch.load_data <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (kind == IN_LOAD) begin
            n_loads++;
        end else begin
            n_execs++;
        end
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic write_video_base(input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        n_cfg_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [15:0] random_instr();
        logic [3:0]  op;
        logic [15:0] w;
        op = 4'($urandom_range(0, 15));
        w = {op, 12'($urandom)};
        case (op)
            OP_WMEM: begin
                if ($urandom_range(0, 3) != 0) w[11:8] = 4'd0;
            end
            OP_JUMP: begin
                if ($urandom_range(0, 3) == 0) begin
                    w[11:0] = JUMP_RET;
                end else if ($urandom_range(0, 1) == 0) begin
                    w[11:0] = 12'($signed(5'($urandom_range(0, 31))));
                end
            end
            OP_MISC: begin
                if ($urandom_range(0, 3) != 0) begin
                    w[7:4] = $urandom_range(0, 1) ? SUB_COPY : SUB_RMEM;
                end
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    // mostly load-then-run sequences, so every fetch and rmem hits a loaded word
    task automatic pick_and_send();
        logic [15:0] pc_idx;
        logic [15:0] w;
        logic [15:0] dptr;
        int roll;
        pc_idx = chk.pc_q & ADDR_MASK;
        w = chk.mem_q[pc_idx];
        dptr = chk.regs_q[w[3:0]] & ADDR_MASK;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            send_word(IN_LOAD, 16'($urandom), 16'($urandom));
        end else if (roll < 12 || !chk.loaded_q[pc_idx]) begin
            send_word(IN_LOAD, pc_idx, random_instr());
        end else if (w[15:12] == OP_MISC && w[7:4] == SUB_RMEM && !chk.loaded_q[dptr]) begin
            send_word(IN_LOAD, dptr, 16'($urandom));
        end else begin
            send_word(IN_EXEC, 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin : sink_pattern
        int mode;
        int mode_left;
        int stall_left;
        out_ch.ready = 1'b1;
        mode = 0;
        mode_left = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(40, 300);
            end else begin
                mode_left--;
            end
            if (mode == 0) begin
                out_ch.ready <= 1'b1;
            end else if (mode == 1) begin
                out_ch.ready <= 1'($urandom_range(0, 1));
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 8);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still pending", cycle_count,
                 pending_count);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] vb;
        int burst_left;
        int phase_end;
        bit no_gaps;
        in_ch.valid = 1'b0;
        in_ch.opcode = IN_LOAD;
        in_ch.load_address = '0;
        in_ch.load_data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        n_loads = 0;
        n_execs = 0;
        n_cfg_writes = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // short program at reset video_base: sign extension, shift by 16, skip over a slot,
        // an illegal word, store and load in the display area, call and return, add wrap
        send_word(IN_LOAD, 16'hffff, 16'hffff);
        send_word(IN_LOAD, 16'h0005, 16'h0000);
        send_word(IN_LOAD, 16'h0000, 16'hc5ff);
        send_word(IN_LOAD, 16'h0001, 16'hd17f);
        send_word(IN_LOAD, 16'h0002, 16'hc210);
        send_word(IN_LOAD, 16'h0003, 16'h9452);
        send_word(IN_LOAD, 16'h0004, 16'h3b50);
        send_word(IN_LOAD, 16'h0006, 16'he123);
        send_word(IN_LOAD, 16'h0007, 16'h0015);
        send_word(IN_LOAD, 16'h0008, 16'hf805);
        send_word(IN_LOAD, 16'h0009, 16'ha002);
        send_word(IN_LOAD, 16'h0020, 16'hb001);
        send_word(IN_LOAD, 16'h000a, 16'h1f51);
        repeat (11) send_word(IN_EXEC, 16'($urandom), 16'($urandom));

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            case (ph)
                0:       vb = 16'h0000;
                1:       vb = 16'hffff;
                3:       vb = VIDEO_BASE_RST;
                default: vb = 16'($urandom);
            endcase
            write_video_base(vb);
            no_gaps = (ph == 2);
            phase_end = ITEM_TARGET * (ph + 1) / RAND_PHASES;
            burst_left = 0;
            while (n_loads + n_execs < phase_end) begin
                if (!no_gaps && burst_left == 0) begin
                    idle_cycles($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 24);
                end
                if ($urandom_range(0, 199) == 0) begin
                    drain();
                end
                pick_and_send();
                if (burst_left > 0) burst_left--;
            end
        end

        drain();
        repeat (10) @(negedge i_clk);

        $display("run covered %0d load words and %0d execute words over %0d video_base settings",
                 n_loads, n_execs, n_cfg_writes + 1);
        $display("%0d results compared, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hdl/tcpu_pkg.sv
hdl/tcpu_in_if.sv
hdl/tcpu_out_if.sv
hdl/tcpu_cfg_if.sv
hdl/tcpu_ram.sv
hdl/tcpu_regfile.sv
hdl/tcpu_alu.sv
hdl/teaching_cpu_execute_step_top.sv
tb/sv/tb_tcpu_checker.sv
tb/sv/tb_teaching_cpu_execute_step_top.sv
